@@ src/csvtok_pkg.sv @@
// Shared types and byte constants for the CSV byte tokenizer.
// Used by csvtok_step and csv_byte_tokenizer; no dependencies.
`timescale 1ns / 1ps

package csvtok_pkg;

    localparam logic [7:0] BYTE_QUOTE    = 8'h22;
    localparam logic [7:0] BYTE_CR       = 8'h0D;
    localparam logic [7:0] BYTE_LF       = 8'h0A;
    localparam logic [7:0] SEP_RESET    = 8'd44;

    typedef enum logic [1:0] {
        MODE_OUTSIDE = 2'd0,
        MODE_INSIDE  = 2'd1,
        MODE_PENDING = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_CONTENT   = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_ROW_END   = 2'd2
    } kind_t;

    typedef struct packed {
        mode_t mode;
        logic  after_cr;
        logic  row_open;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{mode: MODE_OUTSIDE, after_cr: 1'b0,
                                             row_open: 1'b0};

    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic [7:0] char_value;
    } token_t;

endpackage

@@ src/csvtok_step.sv @@
// Per-word parse step: next parser state and the optional token for one word.
// Depends on csvtok_pkg.
`timescale 1ns / 1ps

module csvtok_step (
    input  csvtok_pkg::parse_state_t cur_state,
    input  logic [7:0]               data_byte,
    input  logic                     end_of_input,
    input  logic [7:0]               field_separator,
    output csvtok_pkg::parse_state_t next_state,
    output csvtok_pkg::token_t       token
);
    import csvtok_pkg::*;

    always_comb
    begin
        logic go_outside;
        go_outside = 1'b0;
        next_state = cur_state;
        token.valid = 1'b0;
        token.kind = KIND_CONTENT;
        token.char_value = 8'd0;

        if (end_of_input)
        begin
            next_state = STATE_RESET;
            token.valid = cur_state.row_open;
            token.kind = KIND_ROW_END;
        end
        else if (cur_state.after_cr && (data_byte == BYTE_LF))
        begin
            next_state.after_cr = 1'b0;
        end
        else
        begin
            next_state.after_cr = 1'b0;
            next_state.row_open = 1'b1;
            case (cur_state.mode)
                MODE_INSIDE:
                begin
                    if (data_byte == BYTE_QUOTE)
                    begin
                        next_state.mode = MODE_PENDING;
                    end
                    else
                    begin
                        token.valid = 1'b1;
                        token.char_value = data_byte;
                    end
                end
                MODE_PENDING:
                begin
                    if (data_byte == BYTE_QUOTE)
                    begin
                        next_state.mode = MODE_INSIDE;
                        token.valid = 1'b1;
                        token.char_value = BYTE_QUOTE;
                    end
                    else
                    begin
                        go_outside = 1'b1;
                    end
                end
                default:
                begin
                    go_outside = 1'b1;
                end
            endcase

            if (go_outside)
            begin
                if (data_byte == BYTE_QUOTE)
                begin
                    next_state.mode = MODE_INSIDE;
                end
                else
                begin
                    next_state.mode = MODE_OUTSIDE;
                    token.valid = 1'b1;
                    if (data_byte == field_separator)
                    begin
                        token.kind = KIND_FIELD_END;
                    end
                    else if (data_byte == BYTE_CR)
                    begin
                        next_state.after_cr = 1'b1;
                        next_state.row_open = 1'b0;
                        token.kind = KIND_ROW_END;
                    end
                    else if (data_byte == BYTE_LF)
                    begin
                        next_state.row_open = 1'b0;
                        token.kind = KIND_ROW_END;
                    end
                    else
                    begin
                        token.char_value = data_byte;
                    end
                end
            end
        end
    end

endmodule

@@ src/csv_byte_tokenizer.sv @@
// Top level of the CSV byte tokenizer: input register, parse step, result register.
// Depends on csvtok_pkg and csvtok_step.
//
//  Channel  Handshake                 Payload
//  in       in_valid / in_stall       data_byte[7:0], end_of_input
//  out      out_valid / out_stall     result_kind[1:0], char_value[7:0]
//  cfg      cfg_wr_en                 cfg_wr_data[7:0] (field separator)
//
// One word is taken per clock unless stalled; its token, if any, fills the result register.
// The parse state updates when a word moves from the input register to the result register.
// A held result stalls only the input register; the input side stalls when it is also full.
// Reset clears the parse state and sets the separator to a comma.
`timescale 1ns / 1ps

module csv_byte_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] result_kind,
    output logic [7:0] char_value,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);
    import csvtok_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_end_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic [7:0]   sep_reg;
    logic         out_valid_reg;
    kind_t        out_kind_reg;
    logic [7:0]   out_char_reg;
    token_t       token;
    logic         out_free;
    logic         advance;
    logic         accept;

    csvtok_step u_step (
        .cur_state       (state_reg),
        .data_byte       (in_byte_reg),
        .end_of_input    (in_end_reg),
        .field_separator (sep_reg),
        .next_state      (state_next),
        .token           (token)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= STATE_RESET;
            sep_reg       <= SEP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sep_reg <= cfg_wr_data;
            end
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && token.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= data_byte;
            in_end_reg  <= end_of_input;
        end
        if (advance && token.valid)
        begin
            out_kind_reg <= token.kind;
            out_char_reg <= token.char_value;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign char_value  = out_char_reg;

    a_char_zero_unless_content: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg != KIND_CONTENT)) |-> (out_char_reg == 8'd0))
        else $error("Mark word carries a nonzero byte.");

    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_end_reg) |=> (state_reg == STATE_RESET))
        else $error("Parser state not cleared after end of input.");

    a_after_cr_closed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.after_cr |-> (!state_reg.row_open && (state_reg.mode == MODE_OUTSIDE)))
        else $error("After-CR state with open row or quoted mode.");

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg))
        else $error("Input stalled while the pipeline has room.");

    a_state_holds_without_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("Parser state changed with no word processed.");

endmodule

@@ tb/csvtok_checker.sv @@
`timescale 1ns / 1ps
// Checker for csv_byte_tokenizer: predicts the token for each accepted input word and
// compares it with the result channel. Depends on csvtok_pkg.

module csvtok_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] result_kind,
    input  logic [7:0] char_value,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    output int         fail_count,
    output int         tokens_due
);
    import csvtok_pkg::*;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
    } token_rec_t;

    token_rec_t expected_tokens[$];
    logic [7:0] separator;
    mode_t      mode;
    logic       after_cr;
    logic       row_open;
    int         fails;

    function automatic logic tokenize(input logic [7:0] b, input logic eoi,
                                      output token_rec_t tok);
        logic emit;
        emit = 1'b0;
        tok  = '{kind: KIND_CONTENT, ch: 8'h00};
        if (eoi)
        begin
            emit     = row_open;
            tok.kind = KIND_ROW_END;
            mode     = MODE_OUTSIDE;
            after_cr = 1'b0;
            row_open = 1'b0;
        end
        else if (after_cr && b == BYTE_LF)
        begin
            after_cr = 1'b0;
        end
        else
        begin
            after_cr = 1'b0;
            row_open = 1'b1;
            if (mode == MODE_INSIDE)
            begin
                if (b == BYTE_QUOTE)
                begin
                    mode = MODE_PENDING;
                end
                else
                begin
                    emit   = 1'b1;
                    tok.ch = b;
                end
            end
            else if (mode == MODE_PENDING && b == BYTE_QUOTE)
            begin
                mode   = MODE_INSIDE;
                emit   = 1'b1;
                tok.ch = BYTE_QUOTE;
            end
            else if (b == BYTE_QUOTE)
            begin
                mode = MODE_INSIDE;
            end
            else
            begin
                mode = MODE_OUTSIDE;
                emit = 1'b1;
                if (b == separator)
                begin
                    tok.kind = KIND_FIELD_END;
                end
                else if (b == BYTE_CR || b == BYTE_LF)
                begin
                    tok.kind = KIND_ROW_END;
                    after_cr = (b == BYTE_CR);
                    row_open = 1'b0;
                end
                else
                begin
                    tok.ch = b;
                end
            end
        end
        return emit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        token_rec_t tok;
        token_rec_t want;
        if (!rst_n)
        begin
            separator = SEP_RESET;
            mode      = MODE_OUTSIDE;
            after_cr  = 1'b0;
            row_open  = 1'b0;
            fails     = 0;
            expected_tokens.delete();
            fail_count <= 0;
            tokens_due <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected word: result_kind %0d, char_value 8'h%02h",
                           result_kind, char_value);
                    fails++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (result_kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, actual %0d", want.kind, result_kind);
                        fails++;
                    end
                    if (char_value !== want.ch)
                    begin
                        $error("char_value: expected 8'h%02h, actual 8'h%02h", want.ch,
                               char_value);
                        fails++;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                separator = cfg_wr_data;
            end
            if (in_valid && !in_stall)
            begin
                if (tokenize(data_byte, end_of_input, tok))
                begin
                    expected_tokens.insert(expected_tokens.size(), tok);
                end
            end
            fail_count <= fails;
            tokens_due <= expected_tokens.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the csv_byte_tokenizer testbench: clock, reset, stimulus, idling and verdict.
// Depends on csvtok_pkg, csv_byte_tokenizer and csvtok_checker.

module tb_top;
    import csvtok_pkg::*;

    localparam logic [7:0] SEP_TAB    = 8'h09;
    localparam logic [8:0] EOI_WORD   = 9'h100;
    localparam int         WATCHDOG   = 2000;
    localparam int         PHASE_SIZE = 160;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic [7:0] data_byte    = 8'h00;
    logic       end_of_input = 1'b0;
    logic       out_stall    = 1'b0;
    logic       cfg_wr_en    = 1'b0;
    logic [7:0] cfg_wr_data  = 8'h00;
    logic       in_stall;
    logic       out_valid;
    logic [1:0] result_kind;
    logic [7:0] char_value;
    int         fail_count;
    int         tokens_due;
    int         words_sent   = 0;
    int         idle_cycles  = 0;
    bit         idle_on      = 1'b1;

    logic [8:0] directed_words[$] = '{
        9'h000, 9'h0FF, {1'b0, SEP_RESET}, {1'b0, BYTE_QUOTE}, 9'h078,
        {1'b0, BYTE_QUOTE}, {1'b0, BYTE_QUOTE}, 9'h079, {1'b0, BYTE_QUOTE}, 9'h07A,
        {1'b0, BYTE_CR}, {1'b0, BYTE_LF}, {1'b0, BYTE_QUOTE}, {1'b0, SEP_RESET},
        {1'b0, BYTE_QUOTE}, {1'b0, BYTE_LF}, {1'b0, BYTE_LF}, {1'b0, BYTE_CR},
        {1'b0, BYTE_CR}, EOI_WORD, 9'h071, {1'b0, BYTE_QUOTE}, EOI_WORD,
        {1'b0, BYTE_QUOTE}, 9'h061, {1'b0, BYTE_QUOTE}, EOI_WORD, EOI_WORD
    };

    logic [7:0] phase_seps[$] = '{SEP_TAB, BYTE_QUOTE, BYTE_CR, BYTE_LF, 8'h00, 8'hFF,
                                  SEP_RESET};

    csv_byte_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .char_value   (char_value),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    csvtok_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .char_value   (char_value),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .tokens_due   (tokens_due)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG)
            begin
                $display("csv_byte_tokenizer verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic eoi);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        end_of_input <= eoi;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tokens_due != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_separator(input logic [7:0] sep);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sep;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] plain_byte(input logic [7:0] sep);
        logic [7:0] b;
        do
        begin
            b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(32, 126));
        end
        while (b == sep || b == BYTE_QUOTE || b == BYTE_CR || b == BYTE_LF);
        return b;
    endfunction

    task automatic send_row(input logic [7:0] sep);
        int n_fields;
        n_fields = $urandom_range(1, 4);
        for (int f = 0; f < n_fields; f++)
        begin
            if (f != 0)
            begin
                send_word(sep, 1'b0);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                send_word(BYTE_QUOTE, 1'b0);
                repeat ($urandom_range(0, 5))
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        send_word(BYTE_QUOTE, 1'b0);
                        send_word(BYTE_QUOTE, 1'b0);
                    end
                    else
                    begin
                        send_word(8'($urandom_range(0, 255)), 1'b0);
                    end
                end
                send_word(BYTE_QUOTE, 1'b0);
            end
            else
            begin
                repeat ($urandom_range(0, 5)) send_word(plain_byte(sep), 1'b0);
            end
        end
        case ($urandom_range(0, 3))
            0: send_word(BYTE_LF, 1'b0);
            1:
            begin
                send_word(BYTE_CR, 1'b0);
                send_word(BYTE_LF, 1'b0);
            end
            2: send_word(BYTE_CR, 1'b0);
            default: send_word(8'($urandom_range(0, 255)), 1'b1);
        endcase
    endtask

    task automatic send_noise(input logic [7:0] sep);
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(0, 6))
                0: send_word(sep, 1'b0);
                1: send_word(BYTE_QUOTE, 1'b0);
                2: send_word(BYTE_CR, 1'b0);
                3: send_word(BYTE_LF, 1'b0);
                4: send_word(8'($urandom_range(0, 255)), 1'b1);
                default: send_word(8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
    endtask

    initial
    begin
        int target;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_words[i])
        begin
            send_word(directed_words[i][7:0], directed_words[i][8]);
        end

        foreach (phase_seps[p])
        begin
            drain();
            set_separator(phase_seps[p]);
            idle_on = (p != 3) && (p != phase_seps.size() - 1);
            target  = words_sent + PHASE_SIZE;
            while (words_sent < target)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    send_noise(phase_seps[p]);
                end
                else
                begin
                    send_row(phase_seps[p]);
                end
            end
        end

        drain();
        if (fail_count == 0 && tokens_due == 0)
        begin
            $display("csv_byte_tokenizer verification clean");
        end
        else
        begin
            $display("csv_byte_tokenizer verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/csvtok_pkg.sv
src/csvtok_step.sv
src/csv_byte_tokenizer.sv
tb/csvtok_checker.sv
tb/tb_top.sv
